@@ rtl/euler_totient_assert.svh @@
// assertion macros shared by the totient block
// expects clk and rst_n in the scope where a macro is used
`ifndef EULER_TOTIENT_ASSERT_SVH
`define EULER_TOTIENT_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define ETOT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define ETOT_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ rtl/etot_pkg.sv @@
`timescale 1ns / 1ps
// shared constants and types for the totient block
// used by etot_div and euler_totient; no dependencies
package etot_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    // request into the shared divider
    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] dividend;
        logic [WIDTH-1:0] divisor;
    } div_ctl_t;

    // answer from the shared divider
    typedef struct packed {
        logic             done;
        logic [WIDTH-1:0] quotient;
        logic [WIDTH-1:0] remainder;
    } div_sts_t;

endpackage

@@ rtl/etot_div.sv @@
`timescale 1ns / 1ps
// iterative restoring divider, one quotient bit per cycle
// depends on etot_pkg
module etot_div
    import etot_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_ctl_t ctl,
    output div_sts_t sts
);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } div_state_t;

    div_state_t       state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] dvs_reg;
    logic             done_reg;

    logic [WIDTH:0]   rem_shift;
    logic             fits;
    logic [WIDTH:0]   rem_diff;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] quo_next;

    // one trial subtraction
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[WIDTH-1]};
        fits      = (rem_shift >= {1'b0, dvs_reg});
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        rem_next  = fits ? rem_diff[WIDTH-1:0] : rem_shift[WIDTH-1:0];
        quo_next  = {quo_reg[WIDTH-2:0], fits};
    end

    // sequencer and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (ctl.start)
                    begin
                        rem_reg   <= '0;
                        quo_reg   <= ctl.dividend;
                        dvs_reg   <= ctl.divisor;
                        cnt_reg   <= CNT_W'(WIDTH - 1);
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign sts.done      = done_reg;
    assign sts.quotient  = quo_reg;
    assign sts.remainder = rem_reg;

endmodule

@@ rtl/euler_totient.sv @@
`timescale 1ns / 1ps
// Euler totient by trial division around one shared iterative divider
// depends on etot_pkg, etot_div and euler_totient_assert.svh
`include "euler_totient_assert.svh"

// Computes phi(n) for one 32-bit n per input transfer. Every step is one
// pass through the shared bit-serial divider. An item takes about
// c + k + m + 1 passes, where c is the number of candidate divisors
// tried (about floor(sqrt(n')), n' being what is left of n as factors are
// removed), k the number of prime factors found below the bound counted
// with multiplicity and m the number of distinct ones; the worst case is
// a large prime near 2^32, and phi(0) or phi(1) take a single pass. The
// input is not ready while an item is at work; a finished result sits in
// the output register and the next item may be taken while it waits.
module euler_totient
    import etot_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] n_value,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] totient
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_STRIP,
        S_PHI,
        S_LAST,
        S_DONE
    } state_t;

    state_t           state_reg;
    logic [WIDTH-1:0] rest_reg;
    logic [WIDTH-1:0] phi_reg;
    logic [WIDTH-1:0] d_reg;
    logic             div_start_reg;
    logic [WIDTH-1:0] div_a_reg;
    logic [WIDTH-1:0] div_b_reg;
    logic             out_valid_reg;
    logic [WIDTH-1:0] totient_reg;

    div_ctl_t         div_ctl;
    div_sts_t         div_sts;
    logic [WIDTH-1:0] d_inc;

    assign div_ctl.start    = div_start_reg;
    assign div_ctl.dividend = div_a_reg;
    assign div_ctl.divisor  = div_b_reg;

    etot_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .sts   (div_sts)
    );

    assign d_inc = d_reg + WIDTH'(1);

    // trial division sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (out_valid_reg && out_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        rest_reg      <= n_value;
                        phi_reg       <= n_value;
                        d_reg         <= WIDTH'(2);
                        div_a_reg     <= n_value;
                        div_b_reg     <= WIDTH'(2);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_CHECK;
                    end
                end
                // bound test d <= rest / d and divisibility in one pass
                S_CHECK:
                begin
                    if (div_sts.done)
                    begin
                        if (d_reg > div_sts.quotient)
                        begin
                            if (rest_reg > WIDTH'(1))
                            begin
                                div_a_reg     <= phi_reg;
                                div_b_reg     <= rest_reg;
                                div_start_reg <= 1'b1;
                                state_reg     <= S_LAST;
                            end
                            else
                            begin
                                state_reg <= S_DONE;
                            end
                        end
                        else if (div_sts.remainder == '0)
                        begin
                            rest_reg      <= div_sts.quotient;
                            div_a_reg     <= div_sts.quotient;
                            div_b_reg     <= d_reg;
                            div_start_reg <= 1'b1;
                            state_reg     <= S_STRIP;
                        end
                        else
                        begin
                            d_reg         <= d_inc;
                            div_a_reg     <= rest_reg;
                            div_b_reg     <= d_inc;
                            div_start_reg <= 1'b1;
                        end
                    end
                end
                // divide out every further factor d
                S_STRIP:
                begin
                    if (div_sts.done)
                    begin
                        if (div_sts.remainder == '0)
                        begin
                            rest_reg      <= div_sts.quotient;
                            div_a_reg     <= div_sts.quotient;
                            div_start_reg <= 1'b1;
                        end
                        else
                        begin
                            div_a_reg     <= phi_reg;
                            div_start_reg <= 1'b1;
                            state_reg     <= S_PHI;
                        end
                    end
                end
                // phi -= phi / d, then next candidate
                S_PHI:
                begin
                    if (div_sts.done)
                    begin
                        phi_reg       <= phi_reg - div_sts.quotient;
                        d_reg         <= d_inc;
                        div_a_reg     <= rest_reg;
                        div_b_reg     <= d_inc;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_CHECK;
                    end
                end
                // leftover prime factor
                S_LAST:
                begin
                    if (div_sts.done)
                    begin
                        phi_reg   <= phi_reg - div_sts.quotient;
                        state_reg <= S_DONE;
                    end
                end
                // hand the result to the output register once it is free
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        totient_reg   <= phi_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign totient   = totient_reg;

    // checks on the sequencer and divider hand-off
    `ETOT_ASSERT(a_busy, (in_valid && in_ready) |=> !in_ready, "ready after transfer")
    `ETOT_ASSERT(a_div_b, div_start_reg |-> (div_b_reg != '0), "zero divisor at start")
    `ETOT_ASSERT_NEVER(a_done_idle, div_sts.done && (in_ready || state_reg == S_DONE), "stray answer")

endmodule

@@ verif/totient_checker.sv @@
`timescale 1ns / 1ps
// transfer monitor and totient predictor for the totient block
// depends on etot_pkg for the data width
module totient_checker
    import etot_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [WIDTH-1:0] n_value,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [WIDTH-1:0] totient,
    output int               err_count,
    output int               pending
);

    // one awaited result together with the input that caused it
    typedef struct {
        logic [WIDTH-1:0] n;
        logic [WIDTH-1:0] phi;
    } phi_entry_t;

    phi_entry_t phi_q[$];
    phi_entry_t head;

    // phi(n) by trial division, square bound taken as d <= rest / d
    function automatic logic [WIDTH-1:0] phi_of(input logic [WIDTH-1:0] n);
        logic [63:0] rest;
        logic [63:0] acc;
        logic [63:0] d;
        rest = 64'(n);
        acc  = 64'(n);
        for (d = 64'd2; d <= rest / d; d++)
        begin
            if (rest % d == 0)
            begin
                while (rest % d == 0)
                    rest = rest / d;
                acc = acc - acc / d;
            end
        end
        if (rest > 1)
            acc = acc - acc / rest;
        return acc[WIDTH-1:0];
    endfunction

    // compare each output transfer with the oldest prediction, then queue new ones
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (phi_q.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual totient=%0d",
                             $time, totient);
                    err_count <= err_count + 1;
                end
                else
                begin
                    head = phi_q.pop_front();
                    if (totient !== head.phi)
                    begin
                        $display("%0t: totient of n=%0d: expected %0d, actual %0d",
                                 $time, head.n, head.phi, totient);
                        err_count <= err_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                phi_q.push_back('{n_value, phi_of(n_value)});
            pending <= phi_q.size();
        end
    end

endmodule

@@ verif/tb_euler_totient.sv @@
`timescale 1ns / 1ps
// stimulus and verdict for the totient block
// depends on etot_pkg, the top level block and totient_checker
module tb_euler_totient;
    import etot_pkg::*;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic [WIDTH-1:0] n_value   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [WIDTH-1:0] totient;

    int err_count;
    int pending;

    // stretch with no idling on either side
    bit no_idle = 1'b0;
    // request for one long receiver hold-off
    bit rx_hold = 1'b0;

    localparam int HOLD_CYCLES = 2000;
    localparam int RAND_ITEMS  = 70;

    logic [WIDTH-1:0] corner_q[$] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd9, 32'd49, 32'd169, 32'd63001,
        32'd30, 32'd97, 32'd256, 32'd3599, 32'd65521, 32'h0000_FFFF,
        32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000, 32'h8000_0000,
        32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd3486784401
    };

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    euler_totient i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .n_value   (n_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .totient   (totient)
    );

    totient_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .n_value   (n_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .totient   (totient),
        .err_count (err_count),
        .pending   (pending)
    );

    // offer one n, with random gaps, and wait for its transfer
    task automatic send_n(input logic [WIDTH-1:0] n);
        if (!no_idle)
        begin
            while ($urandom_range(99) < 34)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        n_value  <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // hold the input until every queued totient has come out
    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // product of random small factors below a random power of two
    function automatic logic [WIDTH-1:0] smooth_n();
        logic [63:0] acc;
        logic [63:0] cap;
        logic [63:0] f;
        acc = 64'd1;
        cap = 64'd1 << $urandom_range(32, 6);
        f   = 64'($urandom_range(127, 2));
        while (acc * f < cap)
        begin
            acc = acc * f;
            f   = 64'($urandom_range(127, 2));
        end
        return acc[WIDTH-1:0];
    endfunction

    // mostly cheap operands; large ones only with small factors or a factor of 2^16
    function automatic logic [WIDTH-1:0] random_n();
        logic [31:0] raw;
        int          pick;
        raw  = $urandom;
        pick = $urandom_range(99);
        if (pick < 40)
            return {20'h0, raw[11:0]};
        else if (pick < 85)
            return smooth_n();
        else if (pick < 95)
            return {14'h0, raw[17:0]};
        else
            return {raw[15:0], 16'h0};
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        bit hold_taken;
        hold_taken = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= no_idle || ($urandom_range(99) >= 34);
        end
    end

    // stimulus and verdict
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners: zero, one, squares, primes, all-ones and the like
        foreach (corner_q[k])
            send_n(corner_q[k]);
        in_valid <= 1'b0;
        wait_drained();

        // receiver holds off while small items keep coming, so the input stalls
        rx_hold = 1'b1;
        repeat (8)
            send_n($urandom_range(15));
        in_valid <= 1'b0;
        wait_drained();

        // random operands with a stretch of full throughput in the middle
        for (int k = 0; k < RAND_ITEMS; k++)
        begin
            no_idle = (k >= 20 && k < 50);
            send_n(random_n());
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        wait_drained();
        repeat (50) @(posedge clk);
        if (err_count == 0)
            $display("PASS euler_totient");
        else
            $display("FAIL euler_totient");
        $finish;
    end

    // watchdog
    initial
    begin
        #240_000_000;
        $display("FAIL euler_totient");
        $finish;
    end

endmodule
